// File: hdl/bsa_pkg.sv
package bsa_pkg;

	// Default sizes of the map
	localparam int MAP_SLOTS_DEF = 256;
	localparam int WORD_BITS_DEF = 32;

	// Fixed field widths
	localparam int FUNC_W = 2;
	localparam int POS_W  = 8;
	localparam int BIU_W  = 9;
	localparam int RES_W  = POS_W + 2 + BIU_W;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd3;

	// Register index taken from the word address
	localparam logic REG_BITS_IN_USE = 1'b0;

	// Request token that walks the row of map cells
	typedef struct packed {
		logic              valid;
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  position;
		logic [POS_W-1:0]  idx;
		logic              ok;
		logic              was_free;
		logic              done;
		logic              take;
		logic              give_back;
	} token_t;

endpackage

// File: hdl/bitmap_slot_allocator_top.sv
// Bitmap slot allocator: one map bit per slot, set means taken.
// Requests enter on the s_axis channel: tuser carries the operation
// (allocate lowest free, mark, free, test), tdata the slot position.
// One result leaves on m_axis per request: granted or echoed slot, ok,
// was_free and the count of free slots after the operation.
// The map lives in a row of MAP_WORDS cells, one map word each; a request
// walks the row one cell per cycle, and its result is loaded into the
// output register (or the hold register) as it leaves the last cell. One
// request is in the row at a time; the next is taken only once the previous
// one has left the row and the hold register is empty.
// A finished result waits in the output register; one more result may
// finish behind it in a hold register, and while that is full s_axis_tready
// stays low. A stalled receiver never loses a result.
// The APB register bits_in_use (address 0) sets the number of managed slots
// and clears the whole map when written; write it only while idle.
// Reset clears the map and sets bits_in_use to 256 (capped at MAP_SLOTS).
module bitmap_slot_allocator_top #(
	parameter int MAP_SLOTS = bsa_pkg::MAP_SLOTS_DEF,
	parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request: s_axis_tuser = func[1:0]; s_axis_tdata = position[7:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	// result: slot_index[7:0], ok[8], was_free[9], free_count[18:10], zero[23:19]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [bsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bsa_pkg::*;

	localparam int MAP_WORDS = (MAP_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int CAP_INT   = (MAP_SLOTS > 511) ? 511 : MAP_SLOTS;
	localparam int RST_INT   = (MAP_SLOTS < 256) ? MAP_SLOTS : 256;
	localparam logic [BIU_W-1:0] BIU_MAX = BIU_W'(CAP_INT);
	localparam logic [BIU_W-1:0] BIU_RST = BIU_W'(RST_INT);

	token_t              chain [MAP_WORDS+1];
	token_t              head;
	token_t              tail;
	logic [MAP_WORDS:0]  tok_vld;
	logic                in_acc, cfg_wr, reg_sel;
	logic [BIU_W-1:0]    biu_q, biu_new, clear_count_q, cnt_next;
	logic                busy_q, out_valid_q, hold_valid_q;
	logic [RES_W-1:0]    res_d, out_q, hold_q;
	logic                load_out, drain_out;

	// Register write decode; misaligned addresses hit nothing
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_BITS_IN_USE) && (paddr[1:0] == 2'b00);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign biu_new = (pwdata[BIU_W-1:0] > BIU_MAX) ? BIU_MAX : pwdata[BIU_W-1:0];
	assign prdata  = reg_sel ? 32'(biu_q) : 32'd0;

	// Build the entry token
	assign s_axis_tready = !busy_q && !hold_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		head           = '0;
		head.valid     = in_acc;
		head.func      = s_axis_tuser;
		head.position  = s_axis_tdata;
		head.idx       = (s_axis_tuser == FUNC_ALLOC) ? '0 : s_axis_tdata;
		head.ok        = (s_axis_tuser != FUNC_ALLOC) &&
			(BIU_W'(s_axis_tdata) < biu_q);
	end

	assign chain[0] = head;

	// Row of map cells, one word each
	for (genvar g = 0; g < MAP_WORDS; g++) begin : g_cell
		bsa_cell #(
			.WORD_BITS(WORD_BITS),
			.CELL_IDX (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wipe       (cfg_wr),
			.bits_in_use(biu_q),
			.tok_in     (chain[g]),
			.tok_out    (chain[g+1])
		);
	end

	for (genvar g = 0; g <= MAP_WORDS; g++) begin : g_vld
		assign tok_vld[g] = chain[g].valid;
	end

	assign tail = chain[MAP_WORDS];

	// Update the free count from what the row did
	always_comb begin
		cnt_next = clear_count_q;
		if (tail.take && (clear_count_q != '0)) begin
			cnt_next = clear_count_q - BIU_W'(1);
		end else if (tail.give_back) begin
			cnt_next = clear_count_q + BIU_W'(1);
		end
	end

	assign res_d = {cnt_next, tail.was_free, tail.ok, tail.idx};

	// Settings and running count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q         <= BIU_RST;
			clear_count_q <= BIU_RST;
		end else if (cfg_wr) begin
			biu_q         <= biu_new;
			clear_count_q <= biu_new;
		end else if (tail.valid) begin
			clear_count_q <= cnt_next;
		end
	end

	// Track the item in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
		end else if (tail.valid) begin
			busy_q <= 1'b0;
		end
	end

	// Output register with one hold stage behind it
	assign drain_out = out_valid_q && m_axis_tready;
	assign load_out  = tail.valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (tail.valid) begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else begin
				hold_valid_q <= 1'b1;
			end
		end else if (drain_out) begin
			if (hold_valid_q) begin
				hold_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			if (load_out) begin
				out_q <= res_d;
			end else begin
				hold_q <= res_d;
			end
		end else if (drain_out && hold_valid_q) begin
			out_q <= hold_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_q);

	// Only one request walks the row at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one token in the cell row");

	// The free count never exceeds the number of managed slots
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		clear_count_q <= biu_q)
		else $error("free count above bits_in_use");

	// A held result always has a result in front of it
	a_hold_order: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> out_valid_q)
		else $error("hold stage full with output empty");

	// A token leaves the row only for an item in flight
	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("token left the row while idle");

	// A free slot report always comes with ok
	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_q[POS_W+1]) |-> out_q[POS_W])
		else $error("was_free set without ok");

endmodule

// File: hdl/bsa_cell.sv
module bsa_cell #(
	parameter int WORD_BITS = bsa_pkg::WORD_BITS_DEF,
	parameter int CELL_IDX  = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wipe,
	input  logic [bsa_pkg::BIU_W-1:0] bits_in_use,
	input  bsa_pkg::token_t          tok_in,
	output bsa_pkg::token_t          tok_out
);
	import bsa_pkg::*;

	localparam int BASE  = CELL_IDX * WORD_BITS;
	localparam int BIT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	logic [WORD_BITS-1:0] word_q, word_d;
	logic [WORD_BITS-1:0] in_lim, avail, low_one;
	logic [BIT_W-1:0]     low_idx, pos_bit;
	logic                 pos_hit, bit_set;
	token_t               tok_d, tok_q;

	// Mark the bits of this word that lie below the slot limit
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			in_lim[b] = (32'(BASE + b) < 32'(bits_in_use));
		end
	end

	// Isolate the lowest free slot and encode its bit number
	assign avail   = ~word_q & in_lim;
	assign low_one = avail & (~avail + WORD_BITS'(1));

	always_comb begin
		low_idx = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (low_one[b]) begin
				low_idx = low_idx | BIT_W'(b);
			end
		end
	end

	// Locate the addressed slot within this word
	assign pos_hit = (32'(tok_in.position) >= 32'(BASE)) &&
		(32'(tok_in.position) < 32'(BASE + WORD_BITS));
	assign pos_bit = BIT_W'(32'(tok_in.position) - 32'(BASE));
	assign bit_set = pos_hit && word_q[pos_bit];

	// Apply the operation carried by the token
	always_comb begin
		word_d = word_q;
		tok_d  = tok_in;
		if (tok_in.valid) begin
			unique case (tok_in.func)
				FUNC_ALLOC: begin
					if (!tok_in.done && (|avail)) begin
						word_d         = word_q | low_one;
						tok_d.done     = 1'b1;
						tok_d.idx      = POS_W'(BASE + int'(low_idx));
						tok_d.ok       = 1'b1;
						tok_d.was_free = 1'b1;
						tok_d.take     = 1'b1;
					end
				end
				FUNC_MARK: begin
					if (tok_in.ok && pos_hit) begin
						tok_d.was_free = !bit_set;
						if (!bit_set) begin
							word_d[pos_bit] = 1'b1;
							tok_d.take      = 1'b1;
						end
					end
				end
				FUNC_FREE: begin
					if (tok_in.ok && pos_hit) begin
						tok_d.was_free = !bit_set;
						if (bit_set) begin
							word_d[pos_bit] = 1'b0;
							tok_d.give_back = 1'b1;
						end
					end
				end
				FUNC_TEST: begin
					if (tok_in.ok && pos_hit) begin
						tok_d.was_free = !bit_set;
					end
				end
				default: ;
			endcase
		end
	end

	// Hold the map word; wipe it on a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (wipe) begin
			word_q <= '0;
		end else begin
			word_q <= word_d;
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule
